// File: sv/aabbp_pkg.sv
// shared types and constants for the aabb push-out block
`default_nettype none

package aabbp_pkg;

    localparam int unsigned MAX_OBSTACLES_DEF = 64;
    localparam int unsigned WALK_CAP          = 64;
    localparam int unsigned POS_W             = 20;
    localparam int unsigned SIZE_W            = 18;
    localparam int unsigned IDX_W             = 6;
    localparam int unsigned CNT_W             = 7;
    localparam int unsigned DIR_W             = 2;
    localparam int unsigned S_TDATA_W         = 88;
    localparam int unsigned M_TDATA_W         = 48;

    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_RESOLVE = 1'b1;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    // object box travelling along the cell row
    typedef struct packed {
        logic                     valid;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic        [SIZE_W-1:0] w;
        logic        [SIZE_W-1:0] h;
    } t_tok;

    // one obstacle write towards the cells
    typedef struct packed {
        logic                     wr;
        logic        [IDX_W-1:0]  idx;
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic        [SIZE_W-1:0] sx;
        logic        [SIZE_W-1:0] sy;
    } t_load;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } t_state;

endpackage

`default_nettype wire

// File: sv/aabbp_cell.sv
// one obstacle cell: stores a box, tests the passing object and pushes it out
`default_nettype none

module aabbp_cell #(
    parameter int unsigned IDX = 0
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_adv,
    input  wire [aabbp_pkg::CNT_W-1:0]     i_count,
    input  aabbp_pkg::t_load               i_load,
    input  aabbp_pkg::t_tok                i_tok,
    output aabbp_pkg::t_tok                o_tok,
    output logic                           o_hit,
    output logic [aabbp_pkg::DIR_W-1:0]    o_dir
);

    localparam int unsigned CNT_W = aabbp_pkg::CNT_W;

    logic signed [aabbp_pkg::POS_W-1:0]  r_cx, r_cy;
    logic        [aabbp_pkg::SIZE_W-1:0] r_sx, r_sy;
    aabbp_pkg::t_tok                     r_tok, n_tok;
    logic                                r_hit, n_hit;
    logic [aabbp_pkg::DIR_W-1:0]         r_dir, n_dir;

    logic [18:0]        sum_x, sum_y;
    logic signed [20:0] dif_x, dif_y;
    logic [20:0]        abs_x, abs_y;
    logic [21:0]        dbl_x, dbl_y;
    logic               ov_x, ov_y, ypush, cgt, active;
    logic [21:0]        pen_x, pen_y;
    logic [18:0]        pen;
    logic [19:0]        pen_r;
    logic [18:0]        mag;
    logic signed [19:0] coord;
    logic signed [21:0] moved;
    logic signed [19:0] sat;

    always_comb begin
        sum_x = {1'b0, r_sx} + {1'b0, i_tok.w};
        sum_y = {1'b0, r_sy} + {1'b0, i_tok.h};
        dif_x = {r_cx[19], r_cx} - {i_tok.x[19], i_tok.x};
        dif_y = {r_cy[19], r_cy} - {i_tok.y[19], i_tok.y};
        abs_x = dif_x[20] ? 21'(-dif_x) : 21'(dif_x);
        abs_y = dif_y[20] ? 21'(-dif_y) : 21'(dif_y);
        dbl_x = {abs_x, 1'b0};
        dbl_y = {abs_y, 1'b0};
        ov_x  = {3'b000, sum_x} > dbl_x;
        ov_y  = {3'b000, sum_y} > dbl_y;
        pen_x = {3'b000, sum_x} - dbl_x;
        pen_y = {3'b000, sum_y} - dbl_y;
        ypush = pen_x[18:0] > pen_y[18:0];
        pen   = ypush ? pen_y[18:0] : pen_x[18:0];
        // half penetration, a half step rounds up
        pen_r = {1'b0, pen} + 20'd1;
        mag   = pen_r[19:1];
        coord = ypush ? i_tok.y : i_tok.x;
        cgt   = ypush ? (r_cy > i_tok.y) : (r_cx > i_tok.x);
        moved = cgt ? ({{2{coord[19]}}, coord} - {3'b000, mag})
                    : ({{2{coord[19]}}, coord} + {3'b000, mag});
        if (moved > 22'sd524287) begin
            sat = 20'sd524287;
        end else if (moved < -22'sd524288) begin
            sat = -20'sd524288;
        end else begin
            sat = moved[19:0];
        end
        active = i_tok.valid && (CNT_W'(IDX) < i_count);
        n_hit  = active && ov_x && ov_y;
        n_tok  = i_tok;
        if (n_hit) begin
            if (ypush) begin
                n_tok.y = sat;
            end else begin
                n_tok.x = sat;
            end
        end
        unique case ({ypush, cgt})
            2'b11:   n_dir = aabbp_pkg::DIR_DOWN;
            2'b10:   n_dir = aabbp_pkg::DIR_UP;
            2'b01:   n_dir = aabbp_pkg::DIR_RIGHT;
            default: n_dir = aabbp_pkg::DIR_LEFT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load.wr && (i_load.idx == aabbp_pkg::IDX_W'(IDX))) begin
            r_cx <= i_load.cx;
            r_cy <= i_load.cy;
            r_sx <= i_load.sx;
            r_sy <= i_load.sy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
            r_hit       <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dir <= n_dir;
        end
    end

    assign o_tok = r_tok;
    assign o_hit = r_hit && r_tok.valid;
    assign o_dir = r_dir;

endmodule

`default_nettype wire

// File: sv/aabb_collision_push_out.sv
// top level: obstacle cell row, result hold stage and output register
`default_nettype none

// Obstacle boxes sit in a row of cells, one box per cell, written by load
// requests (tuser 0), each acknowledged through the output register. A resolve
// request (tuser 1) enters the first cell and moves one cell per clock while no
// hit waits on a stalled output; each cell whose index is below obstacle_count
// tests it and pushes it out on a strict overlap. A resolve always travels the
// whole row (MAX_OBSTACLES, at most 64) whatever obstacle_count is, so the row
// length, not obstacle_count, sets how long it takes. Only one request is in the
// block at a time. Each hit is held back until the next hit or the end of the
// walk, so that the last hit of a walk can carry tlast.
module aabb_collision_push_out #(
    parameter int unsigned MAX_OBSTACLES = aabbp_pkg::MAX_OBSTACLES_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    // configuration: obstacle_count
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire [aabbp_pkg::CNT_W-1:0]       i_cfg_data,
    // request stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // entry_index, center_x, center_y, size_x, size_y
    input  wire [aabbp_pkg::S_TDATA_W-1:0]   s_tdata,
    // action
    input  wire                              s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // direction, obstacle_index, new_x, new_y
    output logic [aabbp_pkg::M_TDATA_W-1:0]  m_tdata,
    // hit
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int unsigned NCELL = (MAX_OBSTACLES < aabbp_pkg::WALK_CAP) ?
                                    MAX_OBSTACLES : aabbp_pkg::WALK_CAP;

    // request field unpacking
    logic [aabbp_pkg::IDX_W-1:0]         in_idx;
    logic signed [aabbp_pkg::POS_W-1:0]  in_cx, in_cy;
    logic [aabbp_pkg::SIZE_W-1:0]        in_sx, in_sy;
    assign in_idx = s_tdata[5:0];
    assign in_cx  = s_tdata[25:6];
    assign in_cy  = s_tdata[45:26];
    assign in_sx  = s_tdata[63:46];
    assign in_sy  = s_tdata[81:64];

    aabbp_pkg::t_state r_state, n_state;
    logic [aabbp_pkg::CNT_W-1:0] r_count;

    // output register
    logic                                r_o_valid;
    logic                                r_o_hit, r_o_last;
    logic [aabbp_pkg::DIR_W-1:0]         r_o_dir;
    logic [aabbp_pkg::IDX_W-1:0]         r_o_idx;
    logic signed [aabbp_pkg::POS_W-1:0]  r_o_x, r_o_y;

    // held hit, released once we know whether it is the last
    logic                                r_h_valid;
    logic [aabbp_pkg::DIR_W-1:0]         r_h_dir;
    logic [aabbp_pkg::IDX_W-1:0]         r_h_idx;
    logic signed [aabbp_pkg::POS_W-1:0]  r_h_x, r_h_y;

    // object position after the walk, for the no-hit result
    logic signed [aabbp_pkg::POS_W-1:0]  r_f_x, r_f_y;

    aabbp_pkg::t_tok  tok_in  [NCELL];
    aabbp_pkg::t_tok  tok_out [NCELL];
    logic [NCELL-1:0] hit_v;
    logic [aabbp_pkg::DIR_W-1:0] dir_v [NCELL];
    aabbp_pkg::t_load load;

    logic out_free, can_take, pend, adv, s_acc, walk_end;
    logic [aabbp_pkg::DIR_W-1:0]         sel_dir;
    logic [aabbp_pkg::IDX_W-1:0]         sel_idx;
    logic signed [aabbp_pkg::POS_W-1:0]  sel_x, sel_y;

    assign out_free = !r_o_valid || m_tready;
    assign can_take = !r_h_valid || out_free;
    assign adv      = !pend || can_take;
    assign s_acc    = s_tvalid && s_tready;
    assign walk_end = tok_out[NCELL-1].valid && adv;

    assign load.wr  = s_acc && (s_tuser == aabbp_pkg::ACT_LOAD);
    assign load.idx = in_idx;
    assign load.cx  = in_cx;
    assign load.cy  = in_cy;
    assign load.sx  = in_sx;
    assign load.sy  = in_sy;

    assign tok_in[0] = '{valid: s_acc && (s_tuser == aabbp_pkg::ACT_RESOLVE),
                         x: in_cx, y: in_cy, w: in_sx, h: in_sy};

    genvar g;
    generate
        for (g = 0; g < NCELL; g++) begin : g_cell
            if (g > 0) begin : g_link
                assign tok_in[g] = tok_out[g-1];
            end
            aabbp_cell #(.IDX(g)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_count (r_count),
                .i_load  (load),
                .i_tok   (tok_in[g]),
                .o_tok   (tok_out[g]),
                .o_hit   (hit_v[g]),
                .o_dir   (dir_v[g])
            );
        end
    endgenerate

    // at most one cell holds the object, so an or-of-ands picks its result
    always_comb begin
        pend    = |hit_v;
        sel_dir = '0;
        sel_idx = '0;
        sel_x   = '0;
        sel_y   = '0;
        for (int i = 0; i < NCELL; i++) begin
            if (hit_v[i]) begin
                sel_dir = sel_dir | dir_v[i];
                sel_idx = sel_idx | aabbp_pkg::IDX_W'(i);
                sel_x   = sel_x | tok_out[i].x;
                sel_y   = sel_y | tok_out[i].y;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            aabbp_pkg::ST_IDLE: begin
                if (s_acc && (s_tuser == aabbp_pkg::ACT_RESOLVE)) begin
                    n_state = aabbp_pkg::ST_WALK;
                end
            end
            aabbp_pkg::ST_WALK: begin
                if (walk_end) begin
                    n_state = aabbp_pkg::ST_FLUSH;
                end
            end
            aabbp_pkg::ST_FLUSH: begin
                if (out_free) begin
                    n_state = aabbp_pkg::ST_IDLE;
                end
            end
            default: n_state = aabbp_pkg::ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = 1'b0;
        unique case (r_state)
            aabbp_pkg::ST_IDLE:  s_tready = out_free;
            aabbp_pkg::ST_WALK:  s_tready = 1'b0;
            aabbp_pkg::ST_FLUSH: s_tready = 1'b0;
            default:             s_tready = 1'b0;
        endcase
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= aabbp_pkg::ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_h_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
            if (out_free) begin
                r_o_valid <= 1'b0;
            end
            // load acknowledge
            if (load.wr) begin
                r_o_valid <= 1'b1;
            end
            // a fresh hit pushes the held one out, not last
            if (pend && can_take) begin
                r_h_valid <= 1'b1;
                if (r_h_valid) begin
                    r_o_valid <= 1'b1;
                end
            end
            // end of walk: held hit or no-hit result, last
            if ((r_state == aabbp_pkg::ST_FLUSH) && out_free) begin
                r_o_valid <= 1'b1;
                r_h_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load.wr) begin
            r_o_hit  <= 1'b0;
            r_o_dir  <= aabbp_pkg::DIR_UP;
            r_o_idx  <= in_idx;
            r_o_x    <= in_cx;
            r_o_y    <= in_cy;
            r_o_last <= 1'b1;
        end else if (pend && can_take && r_h_valid) begin
            r_o_hit  <= 1'b1;
            r_o_dir  <= r_h_dir;
            r_o_idx  <= r_h_idx;
            r_o_x    <= r_h_x;
            r_o_y    <= r_h_y;
            r_o_last <= 1'b0;
        end else if ((r_state == aabbp_pkg::ST_FLUSH) && out_free) begin
            r_o_last <= 1'b1;
            if (r_h_valid) begin
                r_o_hit <= 1'b1;
                r_o_dir <= r_h_dir;
                r_o_idx <= r_h_idx;
                r_o_x   <= r_h_x;
                r_o_y   <= r_h_y;
            end else begin
                r_o_hit <= 1'b0;
                r_o_dir <= aabbp_pkg::DIR_UP;
                r_o_idx <= '0;
                r_o_x   <= r_f_x;
                r_o_y   <= r_f_y;
            end
        end
        if (pend && can_take) begin
            r_h_dir <= sel_dir;
            r_h_idx <= sel_idx;
            r_h_x   <= sel_x;
            r_h_y   <= sel_y;
        end
        if (walk_end) begin
            r_f_x <= tok_out[NCELL-1].x;
            r_f_y <= tok_out[NCELL-1].y;
        end
    end

    assign m_tvalid = r_o_valid;
    assign m_tdata  = {r_o_y, r_o_x, r_o_idx, r_o_dir};
    assign m_tuser  = r_o_hit;
    assign m_tlast  = r_o_last;

endmodule

`default_nettype wire

// File: sv/aabbp_checker.sv
// port-level checks for the aabb push-out block, bound to the top level
`default_nettype none

module aabbp_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire        m_tuser,
    input wire        m_tlast
);

    // result register is empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // acknowledge and no-hit results close their request
    a_nohit_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("non-hit result without last");

    // acknowledge and no-hit results carry direction up
    a_nohit_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tuser |-> m_tdata[1:0] == 2'd0)
        else $error("non-hit result with a direction");

endmodule

bind aabb_collision_push_out aabbp_checker u_aabbp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/tb_aabb_collision_push_out.sv
// testbench for the aabb push-out block: directed table plus random requests
`timescale 1ns / 1ps

module tb_aabb_collision_push_out;
    import aabbp_pkg::*;

    localparam int NSLOT = 64;
    localparam int POS_MAXV = 524287;
    localparam int POS_MINV = -524288;

    // expected result of one request
    typedef struct packed {
        logic                    hit;
        logic [DIR_W-1:0]        dir;
        logic [IDX_W-1:0]        idx;
        logic signed [POS_W-1:0] nx;
        logic signed [POS_W-1:0] ny;
        logic                    last;
    } t_res;

    // one request of the directed table
    typedef struct packed {
        logic                     act;
        logic [IDX_W-1:0]         idx;
        logic signed [POS_W-1:0]  cx;
        logic signed [POS_W-1:0]  cy;
        logic [SIZE_W-1:0]        sx;
        logic [SIZE_W-1:0]        sy;
        logic                     typed;   // expected result typed in
        t_res                     res;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CNT_W-1:0]      i_cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    // entry_index, center_x, center_y, size_x, size_y (low bits first)
    logic [S_TDATA_W-1:0]  s_tdata;
    // action
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // direction, obstacle_index, new_x, new_y (low bits first)
    logic [M_TDATA_W-1:0]  m_tdata;
    // hit
    logic                  m_tuser;
    logic                  m_tlast;

    aabb_collision_push_out dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    // predictor copy of the obstacle table and walk length
    logic signed [POS_W-1:0] tab_cx [NSLOT];
    logic signed [POS_W-1:0] tab_cy [NSLOT];
    logic [SIZE_W-1:0]       tab_sx [NSLOT];
    logic [SIZE_W-1:0]       tab_sy [NSLOT];
    bit                      loaded [NSLOT];
    int                      walk_len;

    t_res result_q [$];
    int   mismatches;
    int   cycles;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_recv;

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic longint clamp_pos(longint v);
        if (v > POS_MAXV) return POS_MAXV;
        if (v < POS_MINV) return POS_MINV;
        return v;
    endfunction

    // appends one expected result
    function automatic void queue_result(t_res r);
        result_q = {result_q, r};
    endfunction

    // works out the results of one request and queues them
    function automatic void predict_push_out(logic act, logic [IDX_W-1:0] idx,
            logic signed [POS_W-1:0] cx, logic signed [POS_W-1:0] cy,
            logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy);
        t_res r;
        longint bx, by, ox, oy, sumx, sumy, dx, dy, px, py, m;
        int hits;
        hits = 0;
        if (act == ACT_LOAD) begin
            tab_cx[idx] = cx; tab_cy[idx] = cy;
            tab_sx[idx] = sx; tab_sy[idx] = sy;
            loaded[idx] = 1'b1;
            r = '{1'b0, DIR_UP, idx, cx, cy, 1'b1};
            queue_result(r);
            return;
        end
        bx = cx; by = cy;
        for (int i = 0; i < walk_len; i++) begin
            ox = tab_cx[i]; oy = tab_cy[i];
            sumx = longint'(tab_sx[i]) + longint'(sx);
            sumy = longint'(tab_sy[i]) + longint'(sy);
            dx = 2 * ((ox > bx) ? ox - bx : bx - ox);
            dy = 2 * ((oy > by) ? oy - by : by - oy);
            if (!(sumx > dx && sumy > dy)) continue;
            px = sumx - dx; py = sumy - dy;
            if (px > py) begin
                m = (py + 1) / 2;
                if (oy > by) begin by = clamp_pos(by - m); r.dir = DIR_DOWN; end
                else begin by = clamp_pos(by + m); r.dir = DIR_UP; end
            end else begin
                m = (px + 1) / 2;
                if (ox > bx) begin bx = clamp_pos(bx - m); r.dir = DIR_RIGHT; end
                else begin bx = clamp_pos(bx + m); r.dir = DIR_LEFT; end
            end
            r.hit = 1'b1; r.idx = IDX_W'(i); r.nx = POS_W'(bx); r.ny = POS_W'(by);
            r.last = 1'b0;
            queue_result(r);
            hits++;
        end
        if (hits == 0) begin
            r = '{1'b0, DIR_UP, '0, cx, cy, 1'b1};
            queue_result(r);
        end else
            result_q[$].last = 1'b1;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.hit = m_tuser;
            got.dir = m_tdata[1:0];
            got.idx = m_tdata[7:2];
            got.nx = m_tdata[27:8];
            got.ny = m_tdata[47:28];
            got.last = m_tlast;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end else begin
                want = result_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected hit %0d dir %0d idx %0d x %0d y %0d last %0d,"
                            , want.hit, want.dir, want.idx, want.nx, want.ny, want.last,
                            " got hit %0d dir %0d idx %0d x %0d y %0d last %0d",
                            got.hit, got.dir, got.idx, got.nx, got.ny, got.last);
                end
            end
        end
    end

    // receiver stalls, with a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_tready <= 1'b0;
        else if (hold_recv)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(logic act, logic [IDX_W-1:0] idx,
            logic signed [POS_W-1:0] cx, logic signed [POS_W-1:0] cy,
            logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {6'd0, sy, sx, cy, cx, idx};
        predict_push_out(act, idx, cx, cy, sx, sy);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_count(int n);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= CNT_W'(n);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        walk_len = (n > NSLOT) ? NSLOT : n;
    endtask

    // random resolve box mostly near the loaded cluster
    task automatic random_resolve(bit wide);
        logic signed [POS_W-1:0] cx, cy;
        if (wide || $urandom_range(9) == 0) begin
            cx = POS_W'($urandom); cy = POS_W'($urandom);
        end else begin
            cx = POS_W'($urandom_range(4000) - 2000);
            cy = POS_W'($urandom_range(4000) - 2000);
        end
        send_request(ACT_RESOLVE, IDX_W'($urandom), cx, cy,
                     SIZE_W'($urandom_range(3000)), SIZE_W'($urandom_range(3000)));
    endtask

    task automatic random_load(int slot);
        logic signed [POS_W-1:0] cx, cy;
        logic [SIZE_W-1:0] sx, sy;
        if ($urandom_range(7) == 0) begin
            cx = POS_W'($urandom); cy = POS_W'($urandom);
            sx = SIZE_W'($urandom); sy = SIZE_W'($urandom);
        end else begin
            cx = POS_W'($urandom_range(4000) - 2000);
            cy = POS_W'($urandom_range(4000) - 2000);
            sx = SIZE_W'($urandom_range(1500)); sy = SIZE_W'($urandom_range(1500));
        end
        send_request(ACT_LOAD, IDX_W'(slot), cx, cy, sx, sy);
    endtask

    t_row rows [$];

    // appends one row to the directed table
    function automatic void add_row(t_row r);
        rows = {rows, r};
    endfunction

    initial begin
        int n;
        t_row row;
        mismatches = 0; cycles = 0; hold_recv = 1'b0;
        send_idle_pct = 6; recv_idle_pct = 45;
        walk_len = 0;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: loads acknowledge with their own center, resolves
        // with count 0 return the object unchanged
        add_row('{ACT_RESOLVE, 6'd0, 20'sd100, -20'sd100, 18'd50, 18'd50,
                  1'b1, '{1'b0, DIR_UP, 6'd0, 20'sd100, -20'sd100, 1'b1}});
        add_row('{ACT_LOAD, 6'd0, 20'sd0, 20'sd0, 18'd64, 18'd64,
                  1'b1, '{1'b0, DIR_UP, 6'd0, 20'sd0, 20'sd0, 1'b1}});
        add_row('{ACT_LOAD, 6'd63, 20'sh7FFFF, 20'sh80000, 18'h3FFFF, 18'h3FFFF,
                  1'b1, '{1'b0, DIR_UP, 6'd63, 20'sh7FFFF, 20'sh80000, 1'b1}});
        add_row('{ACT_LOAD, 6'd1, 20'sd200, 20'sd0, 18'd32, 18'd32,
                  1'b0, '0});
        add_row('{ACT_LOAD, 6'd2, 20'sd0, 20'sd200, 18'd0, 18'd0, 1'b0, '0});
        add_row('{ACT_LOAD, 6'd3, 20'sh80000, 20'sh7FFFF, 18'h3FFFF, 18'h3FFFF,
                  1'b0, '0});
        foreach (rows[i]) begin
            row = rows[i];
            if (row.typed) begin
                send_request(row.act, row.idx, row.cx, row.cy, row.sx, row.sy);
                // typed expectation replaces the predicted one
                result_q[$] = row.res;
            end else
                send_request(row.act, row.idx, row.cx, row.cy, row.sx, row.sy);
        end
        drain_results();

        // walk the four loaded slots: x push, y push, tie to x, both
        // directions, boxes at both ends of the range, zero-size slot and object
        write_count(4);
        rows.delete();
        add_row('{ACT_RESOLVE, 6'd0, 20'sd10, 20'sd0, 18'd32, 18'd16, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, -20'sd10, 20'sd0, 18'd32, 18'd32, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sd0, 20'sd10, 18'd64, 18'd64, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sd0, -20'sd10, 18'd64, 18'd64, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sd5, 20'sd5, 18'd3, 18'd3, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sd190, 20'sd0, 18'd40, 18'd60, 1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sh7FFF0, 20'sh7FFF0, 18'h3FFFF, 18'h3FFFF,
                  1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sh80010, 20'sh80010, 18'h3FFFF, 18'h3FFFF,
                  1'b0, '0});
        add_row('{ACT_RESOLVE, 6'd0, 20'sd0, 20'sd0, 18'd0, 18'd0, 1'b0, '0});
        foreach (rows[i])
            send_request(rows[i].act, rows[i].idx, rows[i].cx, rows[i].cy,
                         rows[i].sx, rows[i].sy);
        drain_results();

        // fill every slot so any count is legal
        for (int s = 4; s < NSLOT; s++) begin
            if (s != 63) random_load(s);
        end
        drain_results();

        // random phases over counts including both extremes and oversize
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: n = 64;
                1: n = 127;
                2: n = 0;
                3: n = 1;
                default: n = $urandom_range(2, 63);
            endcase
            if (phase == 2) begin send_idle_pct = 45; recv_idle_pct = 6; end
            if (phase == 4) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_count(n);
            if (phase == 1) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_recv = 1'b1;
                        repeat (400) @(posedge i_clk);
                        hold_recv = 1'b0;
                    end
                    begin
                        repeat (4) random_resolve(1'b0);
                    end
                join
            end
            for (int k = 0; k < 9; k++) begin
                if ($urandom_range(3) == 0)
                    random_load($urandom_range(62));
                else
                    random_resolve(k % 5 == 0);
            end
            drain_results();
        end

        if (mismatches == 0 && result_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
